### design/lookat_view_matrix_assert.svh
// Assertion macros for the look-at view matrix block.
// Expects clk and rst in the scope of use.
`ifndef LOOKAT_VIEW_MATRIX_ASSERT_SVH
`define LOOKAT_VIEW_MATRIX_ASSERT_SVH

// same-cycle implication
`define LVM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/lvm_pkg.sv
// Shared types and constants of the look-at view matrix block.
// Used by the front queue, the back sequencer and the top level.
package lvm_pkg;

  localparam int FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] up;
    logic [2:0][32:0] diff;
    logic             fz;
  } item_t;

endpackage

### design/lvm_front.sv
// Front part: takes command words, forms target minus eye, flags a zero
// forward vector and holds words in a two-entry queue. Uses lvm_pkg.
module lvm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0][31:0]   eye,
  input  logic [2:0][31:0]   target,
  input  logic [2:0][31:0]   up,
  output lvm_pkg::item_t     head,
  output logic               head_valid,
  input  logic               pop
);
  import lvm_pkg::*;

  item_t       mem [2];
  item_t       word_in;
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;

  always_comb begin
    word_in.eye = eye;
    word_in.up  = up;
    for (int k = 0; k < 3; k++) begin
      word_in.diff[k] = 33'($signed(target[k])) - 33'($signed(eye[k]));
    end
    word_in.fz = (word_in.diff == '0);
  end

  assign busy       = (count == 2'd2);
  assign push       = start && !busy;
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= word_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

### design/lvm_isqrt.sv
// Iterative integer square root, two radicand bits a cycle.
// Floor root of a 62-bit value. No package use.
module lvm_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [61:0] s,
  output logic [30:0] root,
  output logic        done
);
  logic        run;
  logic [4:0]  cnt;
  logic [61:0] sh;
  logic [33:0] rem;
  logic [35:0] t;
  logic [35:0] trial;
  logic        ge;

  assign t     = {rem, sh[61:60]};
  assign trial = {3'b000, root, 2'b01};
  assign ge    = (t >= trial);

  always_ff @(posedge clk) begin
    if (go) begin
      sh   <= s;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      sh <= {sh[59:0], 2'b00};
      if (ge) begin
        rem  <= 34'(t - trial);
        root <= {root[29:0], 1'b1};
      end else begin
        rem  <= t[33:0];
        root <= {root[29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd30) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### design/lvm_div.sv
// Restoring divider for unit-vector components, one quotient bit a cycle.
// Gives FRAC_BITS+1 quotient bits; the numerator is known to fit. No package use.
module lvm_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [FRAC_BITS+30:0] num,
  input  logic [30:0]           den,
  output logic [FRAC_BITS:0]    q,
  output logic                  done
);
  localparam int CW = $clog2(FRAC_BITS + 1);

  logic              run;
  logic [CW-1:0]     cnt;
  logic [30:0]       rem;
  logic [FRAC_BITS:0] low;
  logic [31:0]       t;
  logic              ge;

  assign t  = {rem, low[FRAC_BITS]};
  assign ge = (t >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= {1'b0, num[FRAC_BITS+30:FRAC_BITS+1]};
      low <= num[FRAC_BITS:0];
      q   <= '0;
    end else if (run) begin
      low <= {low[FRAC_BITS-1:0], 1'b0};
      if (ge) begin
        rem <= 31'(t - {1'b0, den});
        q   <= {q[FRAC_BITS-1:0], 1'b1};
      end else begin
        rem <= t[30:0];
        q   <= {q[FRAC_BITS-1:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(FRAC_BITS)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### design/lvm_back.sv
// Back part: sequencer with one shared multiply-accumulate, square root and
// divider; builds the axes and translation and emits four rows. Uses lvm_pkg.
module lvm_back #(
  parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  lvm_pkg::item_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           valid,
  output logic [1:0]     row_index,
  output logic [31:0]    col0,
  output logic [31:0]    col1,
  output logic [31:0]    col2,
  output logic [16:0]    col3,
  output logic           last_row,
  output logic           degenerate
);
  import lvm_pkg::*;

  localparam int W_AX = FRAC_BITS + 3;
  localparam int NW   = FRAC_BITS + 31;
  localparam logic [16:0] ONE17 = 17'(64'd1 << FRAC_BITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_SQRT  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  localparam logic [3:0] G_SQ  = 4'd0;
  localparam logic [3:0] G_RC0 = 4'd1;
  localparam logic [3:0] G_RC1 = 4'd2;
  localparam logic [3:0] G_RC2 = 4'd3;
  localparam logic [3:0] G_UA0 = 4'd4;
  localparam logic [3:0] G_UA1 = 4'd5;
  localparam logic [3:0] G_UA2 = 4'd6;
  localparam logic [3:0] G_D0  = 4'd7;
  localparam logic [3:0] G_D1  = 4'd8;
  localparam logic [3:0] G_D2  = 4'd9;

  logic [2:0]  state;
  logic        norm_sel;
  logic [3:0]  grp;
  logic [2:0]  mac_cnt;
  logic [2:0]  mac_last;
  logic [1:0]  dcomp;
  logic [1:0]  row;
  logic        degen;
  logic        sq_go;
  logic        div_go;
  logic [30:0] n_reg;

  logic signed [31:0]     eye_r [3];
  logic signed [31:0]     up_r  [3];
  logic signed [W_AX-1:0] fwd   [3];
  logic signed [W_AX-1:0] rgt   [3];
  logic signed [W_AX-1:0] ua    [3];
  logic [31:0]            trow  [3];
  logic [63:0]            nmag  [3];
  logic                   nsign [3];

  logic signed [65:0] acc;
  logic signed [65:0] prod;
  logic               prod_sub;
  logic signed [32:0] opa;
  logic signed [32:0] opb;
  logic               op_sub;

  logic [65:0]            acc_mag;
  logic [65:0]            acc_rnd;
  logic signed [W_AX-1:0] ua_val;
  logic [31:0]            dot_val;
  logic [63:0]            mx;
  logic [NW-1:0]          num;
  logic [30:0]            root;
  logic                   sq_done;
  logic [FRAC_BITS:0]     q;
  logic                   div_done;
  logic signed [W_AX-1:0] q_ax;
  logic [33:0]            dmag [3];

  function automatic logic signed [32:0] xa(input logic signed [W_AX-1:0] v);
    return 33'(v);
  endfunction

  function automatic logic signed [32:0] xe(input logic signed [31:0] v);
    return 33'(v);
  endfunction

  lvm_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .go   (sq_go),
    .s    (acc[61:0]),
    .root (root),
    .done (sq_done)
  );

  lvm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (num),
    .den  (n_reg),
    .q    (q),
    .done (div_done)
  );

  assign num  = NW'({nmag[dcomp][29:0], {FRAC_BITS{1'b0}}}) + NW'(n_reg[30:1]);
  assign q_ax = nsign[dcomp] ? -W_AX'(q) : W_AX'(q);
  assign pop  = (state == S_IDLE) && head_valid;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dmag[k] = head.diff[k][32] ? 34'(-$signed(head.diff[k])) : 34'(head.diff[k]);
    end
  end

  always_comb begin
    mx = nmag[0];
    if (nmag[1] > mx) mx = nmag[1];
    if (nmag[2] > mx) mx = nmag[2];
  end

  assign mac_last = (grp >= G_RC0 && grp <= G_UA2) ? 3'd2 : 3'd3;

  always_comb begin
    opa    = '0;
    opb    = '0;
    op_sub = 1'b0;
    unique case (grp)
      G_SQ: begin
        opa = $signed({3'b000, nmag[mac_cnt[1:0]][29:0]});
        opb = opa;
      end
      G_RC0: begin
        op_sub = mac_cnt[0];
        opa = mac_cnt[0] ? xe(up_r[2]) : xe(up_r[1]);
        opb = mac_cnt[0] ? xa(fwd[1]) : xa(fwd[2]);
      end
      G_RC1: begin
        op_sub = mac_cnt[0];
        opa = mac_cnt[0] ? xe(up_r[0]) : xe(up_r[2]);
        opb = mac_cnt[0] ? xa(fwd[2]) : xa(fwd[0]);
      end
      G_RC2: begin
        op_sub = mac_cnt[0];
        opa = mac_cnt[0] ? xe(up_r[1]) : xe(up_r[0]);
        opb = mac_cnt[0] ? xa(fwd[0]) : xa(fwd[1]);
      end
      G_UA0: begin
        op_sub = mac_cnt[0];
        opa = mac_cnt[0] ? xa(fwd[2]) : xa(fwd[1]);
        opb = mac_cnt[0] ? xa(rgt[1]) : xa(rgt[2]);
      end
      G_UA1: begin
        op_sub = mac_cnt[0];
        opa = mac_cnt[0] ? xa(fwd[0]) : xa(fwd[2]);
        opb = mac_cnt[0] ? xa(rgt[2]) : xa(rgt[0]);
      end
      G_UA2: begin
        op_sub = mac_cnt[0];
        opa = mac_cnt[0] ? xa(fwd[1]) : xa(fwd[0]);
        opb = mac_cnt[0] ? xa(rgt[0]) : xa(rgt[1]);
      end
      G_D0: begin
        opa = xa(rgt[mac_cnt[1:0]]);
        opb = xe(eye_r[mac_cnt[1:0]]);
      end
      G_D1: begin
        opa = xa(ua[mac_cnt[1:0]]);
        opb = xe(eye_r[mac_cnt[1:0]]);
      end
      G_D2: begin
        opa = xa(fwd[mac_cnt[1:0]]);
        opb = xe(eye_r[mac_cnt[1:0]]);
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  always_comb begin
    acc_mag = acc[65] ? 66'(-acc) : 66'(acc);
    acc_rnd = (acc_mag + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    ua_val  = acc[65] ? -W_AX'(acc_rnd) : W_AX'(acc_rnd);
    if (acc[65]) begin
      dot_val = (acc_rnd > 66'h7FFFFFFF) ? 32'h7FFFFFFF : acc_rnd[31:0];
    end else begin
      dot_val = (acc_rnd > 66'h80000000) ? 32'h80000000 : 32'(32'd0 - acc_rnd[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MAC && mac_cnt < mac_last) begin
      prod     <= opa * opb;
      prod_sub <= op_sub;
    end
    if (state == S_MAC) begin
      if (mac_cnt == 3'd0) acc <= '0;
      else if (mac_cnt <= mac_last) acc <= prod_sub ? acc - prod : acc + prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      norm_sel <= 1'b0;
      grp      <= G_SQ;
      mac_cnt  <= '0;
      dcomp    <= '0;
      row      <= '0;
      degen    <= 1'b0;
      sq_go    <= 1'b0;
      div_go   <= 1'b0;
    end else begin
      sq_go  <= 1'b0;
      div_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (head_valid) begin
            for (int k = 0; k < 3; k++) begin
              eye_r[k] <= $signed(head.eye[k]);
              up_r[k]  <= $signed(head.up[k]);
              nmag[k]  <= 64'(dmag[k]);
              nsign[k] <= head.diff[k][32];
            end
            degen    <= head.fz;
            norm_sel <= 1'b0;
            mac_cnt  <= '0;
            if (head.fz) begin
              for (int k = 0; k < 3; k++) fwd[k] <= '0;
              grp   <= G_RC0;
              state <= S_MAC;
            end else begin
              state <= S_SCALE;
            end
          end
        end
        S_SCALE: begin
          if (mx == '0) begin
            for (int k = 0; k < 3; k++) begin
              if (norm_sel) rgt[k] <= '0;
              else fwd[k] <= '0;
            end
            degen   <= 1'b1;
            grp     <= norm_sel ? G_UA0 : G_RC0;
            mac_cnt <= '0;
            state   <= S_MAC;
          end else if (mx[63:30] != '0) begin
            for (int k = 0; k < 3; k++) nmag[k] <= nmag[k] >> 1;
          end else if (mx[63:29] == '0) begin
            for (int k = 0; k < 3; k++) nmag[k] <= nmag[k] << 1;
          end else begin
            grp     <= G_SQ;
            mac_cnt <= '0;
            state   <= S_MAC;
          end
        end
        S_MAC: begin
          mac_cnt <= mac_cnt + 3'd1;
          if (mac_cnt == mac_last + 3'd1) begin
            mac_cnt <= '0;
            grp     <= grp + 4'd1;
            for (int k = 0; k < 3; k++) begin
              if (grp == 4'(G_RC0 + k)) begin
                nmag[k]  <= acc_mag[63:0];
                nsign[k] <= acc[65];
              end
              if (grp == 4'(G_UA0 + k)) ua[k] <= ua_val;
              if (grp == 4'(G_D0 + k)) trow[k] <= dot_val;
            end
            if (grp == G_SQ) begin
              sq_go <= 1'b1;
              state <= S_SQRT;
            end else if (grp == G_RC2) begin
              norm_sel <= 1'b1;
              state    <= S_SCALE;
            end else if (grp == G_D2) begin
              row   <= '0;
              state <= S_EMIT;
            end
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            n_reg  <= root;
            dcomp  <= '0;
            div_go <= 1'b1;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            for (int k = 0; k < 3; k++) begin
              if (dcomp == 2'(k)) begin
                if (norm_sel) rgt[k] <= q_ax;
                else fwd[k] <= q_ax;
              end
            end
            if (dcomp == 2'd2) begin
              grp     <= norm_sel ? G_UA0 : G_RC0;
              mac_cnt <= '0;
              state   <= S_MAC;
            end else begin
              dcomp  <= dcomp + 2'd1;
              div_go <= 1'b1;
            end
          end
        end
        S_EMIT: begin
          row <= row + 2'd1;
          if (row == 2'd3) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign valid      = (state == S_EMIT);
  assign row_index  = row;
  assign last_row   = (row == 2'd3);
  assign degenerate = degen;

  always_comb begin
    col3 = '0;
    case (row)
      2'd3: begin
        col0 = trow[0];
        col1 = trow[1];
        col2 = trow[2];
        col3 = ONE17;
      end
      default: begin
        col0 = 32'(rgt[row]);
        col1 = 32'(ua[row]);
        col2 = 32'(fwd[row]);
      end
    endcase
  end

endmodule

### design/lookat_view_matrix.sv
// Left-handed look-at view matrix builder: top level.
// Holds lvm_front, lvm_back and the assertions; uses lvm_pkg.
//
// A command word (eye, target, up) is taken when start is high and busy is
// low; a two-word queue takes new words while the previous matrix is built.
// Each matrix comes out as four rows on consecutive cycles, each marked by
// valid for one cycle; the receiver cannot stall them. The forward and right
// vectors are first scaled one bit a cycle; the time per word is then set by
// the shared square root, the one-bit-a-cycle divider run three times per
// axis, and the single shared multiplier.
`include "lookat_view_matrix_assert.svh"
module lookat_view_matrix #(
  parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] eye_x,
  input  logic [31:0] eye_y,
  input  logic [31:0] eye_z,
  input  logic [31:0] target_x,
  input  logic [31:0] target_y,
  input  logic [31:0] target_z,
  input  logic [31:0] up_x,
  input  logic [31:0] up_y,
  input  logic [31:0] up_z,
  output logic        valid,
  output logic [1:0]  row_index,
  output logic [31:0] col0,
  output logic [31:0] col1,
  output logic [31:0] col2,
  output logic [16:0] col3,
  output logic        last_row,
  output logic        degenerate
);
  import lvm_pkg::*;

  item_t head;
  logic  head_valid;
  logic  pop;

  lvm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .eye        ({eye_z, eye_y, eye_x}),
    .target     ({target_z, target_y, target_x}),
    .up         ({up_z, up_y, up_x}),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  lvm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .valid      (valid),
    .row_index  (row_index),
    .col0       (col0),
    .col1       (col1),
    .col2       (col2),
    .col3       (col3),
    .last_row   (last_row),
    .degenerate (degenerate)
  );

  `LVM_ASSERT_NEXT(a_rows_run, valid && !last_row, valid && (row_index == $past(row_index) + 2'd1), "rows of a matrix not consecutive")
  `LVM_ASSERT_NEXT(a_gap_after, valid && last_row, !valid, "row follows directly on a last row")
  `LVM_ASSERT_NOW(a_flag_held, valid && (row_index != 2'd0), $stable(degenerate), "degenerate flag changed inside a matrix")
  `LVM_ASSERT_NOW(a_first_row, valid && !$past(valid), row_index == 2'd0, "matrix does not start at row zero")

endmodule

### verif/testbench.sv
// Self-checking bench for the look-at view matrix block.
// Computes the expected four rows per command word and checks each row.
// Depends on lookat_view_matrix and lvm_pkg.
module testbench;

  localparam int FB = lvm_pkg::FRAC_BITS_DEF;
  localparam int N_RANDOM = 380;

  typedef struct {
    logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz;
  } cmd_t;

  typedef struct {
    logic [1:0]  row;
    logic [31:0] c0, c1, c2;
    logic [16:0] c3;
    logic        last;
    logic        degen;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [31:0] eye_x = 0, eye_y = 0, eye_z = 0;
  logic [31:0] target_x = 0, target_y = 0, target_z = 0;
  logic [31:0] up_x = 0, up_y = 0, up_z = 0;
  logic valid;
  logic [1:0] row_index;
  logic [31:0] col0, col1, col2;
  logic [16:0] col3;
  logic last_row, degenerate;

  cmd_t pending_cmds[$];
  row_t expected_rows[$];
  int idle_pct = 0;
  bit hold_sender = 0;
  bit stimulus_done = 0;
  int mismatches = 0;

  lookat_view_matrix DUT (.*);

  always #2 clk = ~clk;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit unit_vec(input longint v[3], output longint u[3]);
    longint unsigned m[3], mx, s, n, q;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 0;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    n = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + (n >> 1)) / n;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic longint round_frac(longint v);
    longint unsigned m;
    m = (mag(v) + (64'd1 << (FB - 1))) >> FB;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3],
                                 output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic logic [31:0] neg_dot_sat(longint ax[3], longint e[3]);
    longint d;
    d = -round_frac(ax[0] * e[0] + ax[1] * e[1] + ax[2] * e[2]);
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483648) d = -64'sd2147483648;
    return d[31:0];
  endfunction

  function automatic void predict_view_matrix(cmd_t c);
    longint e[3], t[3], u[3], dv[3], fw[3], rc[3], rt[3], ua[3];
    bit degen;
    row_t r;
    e = '{longint'($signed(c.ex)), longint'($signed(c.ey)), longint'($signed(c.ez))};
    t = '{longint'($signed(c.tx)), longint'($signed(c.ty)), longint'($signed(c.tz))};
    u = '{longint'($signed(c.ux)), longint'($signed(c.uy)), longint'($signed(c.uz))};
    for (int i = 0; i < 3; i++) dv[i] = t[i] - e[i];
    degen = !unit_vec(dv, fw);
    cross3(u, fw, rc);
    if (!unit_vec(rc, rt)) degen = 1;
    cross3(fw, rt, ua);
    for (int i = 0; i < 3; i++) ua[i] = round_frac(ua[i]);
    for (int i = 0; i < 3; i++) begin
      r.row = i[1:0];
      r.c0 = rt[i][31:0];
      r.c1 = ua[i][31:0];
      r.c2 = fw[i][31:0];
      r.c3 = 0;
      r.last = 0;
      r.degen = degen;
      expected_rows.push_back(r);
    end
    r.row = 2'd3;
    r.c0 = neg_dot_sat(rt, e);
    r.c1 = neg_dot_sat(ua, e);
    r.c2 = neg_dot_sat(fw, e);
    r.c3 = 17'((64'd1 << FB) & 64'h1FFFF);
    r.last = 1;
    r.degen = degen;
    expected_rows.push_back(r);
  endfunction

  // Driver: hold the word until accepted, then advance.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        predict_view_matrix(pending_cmds.pop_front());
      end
      if ((!start || !busy) && pending_cmds.size() > 0 && !hold_sender &&
          $urandom_range(99) >= idle_pct) begin
        start <= 1;
        eye_x <= pending_cmds[0].ex; eye_y <= pending_cmds[0].ey;
        eye_z <= pending_cmds[0].ez;
        target_x <= pending_cmds[0].tx; target_y <= pending_cmds[0].ty;
        target_z <= pending_cmds[0].tz;
        up_x <= pending_cmds[0].ux; up_y <= pending_cmds[0].uy;
        up_z <= pending_cmds[0].uz;
      end else if (!start || !busy) begin
        start <= 0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    row_t x;
    if (!rst && valid) begin
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected row %0d", row_index);
      end else begin
        x = expected_rows.pop_front();
        if (row_index !== x.row || col0 !== x.c0 || col1 !== x.c1 ||
            col2 !== x.c2 || col3 !== x.c3 || last_row !== x.last ||
            degenerate !== x.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp row %0d %h %h %h %h %b %b, got %0d %h %h %h %h %b %b",
                     x.row, x.c0, x.c1, x.c2, x.c3, x.last, x.degen,
                     row_index, col0, col1, col2, col3, last_row, degenerate);
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000)) - 1000) << FB;
      2: return 32'($signed($urandom_range(64)) - 32);
      3: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF} ^ $urandom_range(3);
      default: return $urandom() >>> $urandom_range(31);
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.ex = rand_coord(); c.ey = rand_coord(); c.ez = rand_coord();
    c.tx = rand_coord(); c.ty = rand_coord(); c.tz = rand_coord();
    c.ux = rand_coord(); c.uy = rand_coord(); c.uz = rand_coord();
    case ($urandom_range(9))
      0: begin c.tx = c.ex; c.ty = c.ey; c.tz = c.ez; end
      1: begin
        c.ux = c.tx - c.ex; c.uy = c.ty - c.ey; c.uz = c.tz - c.ez;
      end
      2: begin c.ux = 0; c.uy = 0; c.uz = 0; end
      default: ;
    endcase
    return c;
  endfunction

  function automatic cmd_t mk(logic [31:0] a, b, cc, d, e, f, g, h, i);
    cmd_t c;
    c.ex = a; c.ey = b; c.ez = cc; c.tx = d; c.ty = e; c.tz = f;
    c.ux = g; c.uy = h; c.uz = i;
    return c;
  endfunction

  task automatic drain();
    wait (pending_cmds.size() == 0 && !start);
    while (expected_rows.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] MX = 32'h7FFF_FFFF;
    localparam logic [31:0] MN = 32'h8000_0000;
    int phase_pct[4];
    phase_pct = '{0, 50, 0, 36};
    repeat (8) @(posedge clk);
    rst <= 0;
    // Directed: plain, degenerate forward, degenerate right, extremes.
    pending_cmds.push_back(mk(0, 0, 0, 0, 0, ONE, 0, ONE, 0));
    pending_cmds.push_back(mk(ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE, 0, ONE, 0));
    pending_cmds.push_back(mk(0, 0, 0, 0, 0, ONE, 0, 0, ONE));
    pending_cmds.push_back(mk(0, 0, 0, 0, 0, ONE, 0, 0, 0));
    pending_cmds.push_back(mk(MN, MN, MN, MX, MX, MX, MX, MN, MX));
    pending_cmds.push_back(mk(MX, MX, MX, MN, MN, MN, MN, MX, MN));
    pending_cmds.push_back(mk(MX, MN, MX, MN, MX, MN, ONE, 0, 0));
    pending_cmds.push_back(mk(MX, MX, MX, MX, MX, MN, 0, ONE, 0));
    pending_cmds.push_back(mk(MN, MN, MN, MN, MN, MX, MX, 0, 0));
    pending_cmds.push_back(mk(0, 0, 0, 1, 0, 0, 0, 1, 0));
    pending_cmds.push_back(mk(5, 0, 0, 0, 0, 0, 0, 0, MN));
    pending_cmds.push_back(mk('1, '1, '1, 0, 0, 0, '1, '1, '1));
    pending_cmds.push_back(mk(MX, MX, MX, MX, MX, MX, MX, MX, MX));
    pending_cmds.push_back(mk(0, 0, 0, 3, 4, 12, MN, MN, MN));
    drain();
    // Pause the sender while new words queue up, then resume.
    hold_sender = 1;
    for (int k = 0; k < 4; k++) pending_cmds.push_back(rand_cmd());
    repeat (30) @(posedge clk);
    hold_sender = 0;
    drain();
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_pct[p];
      for (int k = 0; k < N_RANDOM / 4; k++) pending_cmds.push_back(rand_cmd());
      drain();
    end
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/lvm_pkg.sv
design/lvm_front.sv
design/lvm_isqrt.sv
design/lvm_div.sv
design/lvm_back.sv
design/lookat_view_matrix.sv
verif/testbench.sv
